// File: rtl/dse_pkg.sv
// ----------------------------------------------------------------------------
// dse_pkg
// Shared types and constants for the descending sort engine.
// ----------------------------------------------------------------------------
package dse_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DATA_W       = 32;
    localparam int COUNT_W      = $clog2(MAX_ELEMENTS + 1);

    typedef logic signed [DATA_W-1:0] t_data;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic shift;   // emit mode: take the right neighbor's held entry
    } t_cell_ctl;

endpackage

// File: rtl/dse_cell.sv
// ----------------------------------------------------------------------------
// dse_cell
// One sorting cell: keeps the larger of its held and incoming entry, hands
// the smaller one to the right; shifts left while the list is emitted.
// ----------------------------------------------------------------------------
module dse_cell
    import dse_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_in_valid,
    input  t_data     i_in_value,
    input  logic      i_nbr_valid,
    input  t_data     i_nbr_value,
    output logic      o_pass_valid,
    output t_data     o_pass_value,
    output logic      o_held_valid,
    output t_data     o_held_value
);

    logic  r_held_valid, n_held_valid;
    t_data r_held_value, n_held_value;
    logic  r_pass_valid, n_pass_valid;
    t_data r_pass_value, n_pass_value;

    always_comb begin
        n_held_valid = r_held_valid;
        n_held_value = r_held_value;
        n_pass_valid = 1'b0;
        n_pass_value = i_in_value;
        if (i_ctl.shift) begin
            n_held_valid = i_nbr_valid;
            n_held_value = i_nbr_value;
        end else if (i_in_valid) begin
            if (!r_held_valid) begin
                n_held_valid = 1'b1;
                n_held_value = i_in_value;
            end else if (i_in_value > r_held_value) begin
                // keep the larger, hand the old one on
                n_held_value = i_in_value;
                n_pass_valid = 1'b1;
                n_pass_value = r_held_value;
            end else begin
                n_pass_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_pass_valid <= 1'b0;
        end else begin
            r_held_valid <= n_held_valid;
            r_pass_valid <= n_pass_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_value <= n_held_value;
        r_pass_value <= n_pass_value;
    end

    assign o_pass_valid = r_pass_valid;
    assign o_pass_value = r_pass_value;
    assign o_held_valid = r_held_valid;
    assign o_held_value = r_held_value;

endmodule

// File: rtl/descending_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// descending_sort_engine_unit
// Systolic descending sort of a list of signed 32-bit integers.
// ----------------------------------------------------------------------------
// Feed one list element per input transaction, with i_final_element set on
// the last one. Elements enter a chain of MAX_ELEMENTS cells at one per cycle
// while loading; each cell keeps the larger value and hands the smaller one
// to its right neighbor on the next clock. Elements past capacity are dropped
// and every result of that list carries o_overflow. After the final element
// the unit waits until no element is still moving down the chain, then shifts
// the chain left, emitting one value per output transaction from cell 0,
// largest first, with o_last_of_list on the smallest. Input is not taken
// while settling or emitting.
// ----------------------------------------------------------------------------
module descending_sort_engine_unit
    import dse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_data i_element_value,
    input  logic  i_final_element,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_data o_sorted_value,
    output logic  o_last_of_list,
    output logic  o_overflow
);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SETTLE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_dropped, n_dropped;

    logic [MAX_ELEMENTS-1:0] held_valid;
    t_data                   held_value [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] pass_valid;
    t_data                   pass_value [MAX_ELEMENTS];

    t_cell_ctl cell_ctl;
    logic      in_xfer;
    logic      out_xfer;
    logic      full;
    logic      insert;

    assign full     = (r_count == COUNT_W'(MAX_ELEMENTS));
    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;
    assign insert   = in_xfer && !full;

    assign cell_ctl.shift = out_xfer;

    // ---- chain of cells ----------------------------------------------------
    for (genvar g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
        logic  in_valid;
        t_data in_value;
        logic  nbr_valid;
        t_data nbr_value;

        if (g == 0) begin : g_head
            assign in_valid = insert;
            assign in_value = i_element_value;
        end else begin : g_body
            assign in_valid = pass_valid[g-1];
            assign in_value = pass_value[g-1];
        end

        if (g == MAX_ELEMENTS - 1) begin : g_tail
            assign nbr_valid = 1'b0;
            assign nbr_value = '0;
        end else begin : g_link
            assign nbr_valid = held_valid[g+1];
            assign nbr_value = held_value[g+1];
        end

        dse_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_in_valid   (in_valid),
            .i_in_value   (in_value),
            .i_nbr_valid  (nbr_valid),
            .i_nbr_value  (nbr_value),
            .o_pass_valid (pass_valid[g]),
            .o_pass_value (pass_value[g]),
            .o_held_valid (held_valid[g]),
            .o_held_value (held_value[g])
        );
    end

    // ---- sequencer ---------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        unique case (r_state)
            ST_LOAD: begin
                if (in_xfer) begin
                    // store while room remains, otherwise drop and flag
                    if (full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + COUNT_W'(1);
                    end
                    if (i_final_element) begin
                        n_state = ST_SETTLE;
                    end
                end
            end
            ST_SETTLE: begin
                // hold until nothing is in flight between cells
                if (!(|pass_valid)) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_xfer && o_last_of_list) begin
                    n_state   = ST_LOAD;
                    n_count   = '0;
                    n_dropped = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // ---- ports -------------------------------------------------------------
    assign o_in_ready     = (r_state == ST_LOAD);
    assign o_out_valid    = (r_state == ST_EMIT) && held_valid[0];
    assign o_sorted_value = held_value[0];
    assign o_last_of_list = !held_valid[1];
    assign o_overflow     = r_dropped;

endmodule

// File: rtl/dse_checker.sv
// ----------------------------------------------------------------------------
// dse_checker
// Port-level checks for the descending sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module dse_checker
    import dse_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_in_ready,
    input logic  o_out_valid,
    input logic  i_out_ready,
    input t_data o_sorted_value,
    input logic  o_last_of_list,
    input logic  o_overflow
);

    // no input taken while a list is being emitted
    a_no_load_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while emitting");

    // results come out largest first
    a_descending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_of_list) |=>
            (o_out_valid && (o_sorted_value <= $past(o_sorted_value))))
        else $error("results not in descending order");

    // overflow flag is constant across one list
    a_overflow_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_last_of_list) |=>
            (o_overflow == $past(o_overflow)))
        else $error("overflow changed within a list");

    // after the last result the unit returns to loading
    a_back_to_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_of_list) |=> (!o_out_valid && o_in_ready))
        else $error("unit did not return to loading after last result");

endmodule

bind descending_sort_engine_unit dse_checker u_dse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_sorted_value (o_sorted_value),
    .o_last_of_list (o_last_of_list),
    .o_overflow     (o_overflow)
);

// File: sim/tb_descending_sort_engine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_descending_sort_engine_unit
// Self-checking bench for the systolic descending sort engine.
// ----------------------------------------------------------------------------
// Lists of signed 32-bit elements are pushed through the input channel. The
// bench keeps its own copy of the current list and, on every accepted final
// element, sorts it largest first and queues the expected output transactions
// with their last and overflow flags. Each output transaction is compared
// field by field against the oldest expected one. Directed lists hit the
// extremes, ties and ordering corner cases. A further list fills the chain
// exactly and overflows it, with the final element dropped. Random lists close
// the run under three idle profiles on the two channels.
// ----------------------------------------------------------------------------
module tb_descending_sort_engine_unit;
    import dse_pkg::*;

    typedef struct {
        t_data sorted_value;
        logic  last_of_list;
        logic  overflow;
    } t_sorted_result;

    localparam t_data MOST_NEGATIVE = 32'sh8000_0000;
    localparam t_data MOST_POSITIVE = 32'sh7FFF_FFFF;

    // DUT stimulus, every input known from time zero
    logic  i_clk           = 1'b0;
    logic  i_rst_n         = 1'b0;
    logic  i_in_valid      = 1'b0;
    t_data i_element_value = '0;
    logic  i_final_element = 1'b0;
    logic  i_out_ready     = 1'b0;

    logic  o_in_ready;
    logic  o_out_valid;
    t_data o_sorted_value;
    logic  o_last_of_list;
    logic  o_overflow;

    // predictor state: the list being collected and its expected sorted output
    t_data          pending_list[$];
    logic           pending_dropped = 1'b0;
    t_sorted_result expected_results[$];

    // idle rates in percent, per cycle
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int error_count    = 0;
    int elements_sent  = 0;
    int lists_sent     = 0;
    int overflow_lists = 0;
    int results_seen   = 0;

    descending_sort_engine_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_element_value (i_element_value),
        .i_final_element (i_final_element),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_sorted_value  (o_sorted_value),
        .o_last_of_list  (o_last_of_list),
        .o_overflow      (o_overflow)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor: store the element (or note the drop once the chain is full);
    // on the final element sort the stored list largest first and queue one
    // expected transaction per stored element, then clear for the next list.
    // ------------------------------------------------------------------------
    task automatic predict_sorted_list(input t_data value, input logic is_final);
        t_data          sorted_list[$];
        t_data          key;
        int             j;
        t_sorted_result exp_r;
        if (pending_list.size() < MAX_ELEMENTS) begin
            pending_list.push_back(value);
        end else begin
            pending_dropped = 1'b1;
        end
        elements_sent++;
        if (is_final) begin
            sorted_list = pending_list;
            // insertion sort, signed compare since t_data is signed
            for (int i = 1; i < sorted_list.size(); i++) begin
                key = sorted_list[i];
                j   = i;
                while (j > 0 && key > sorted_list[j-1]) begin
                    sorted_list[j] = sorted_list[j-1];
                    j--;
                end
                sorted_list[j] = key;
            end
            foreach (sorted_list[k]) begin
                exp_r.sorted_value = sorted_list[k];
                exp_r.last_of_list = (k == sorted_list.size() - 1);
                exp_r.overflow     = pending_dropped;
                expected_results.push_back(exp_r);
            end
            lists_sent++;
            if (pending_dropped) begin
                overflow_lists++;
            end
            pending_list.delete();
            pending_dropped = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Send one element. Called at a rising edge; returns at the edge where the
    // transaction was accepted, with valid still high so that a back-to-back
    // element keeps it high without a glitch.
    // ------------------------------------------------------------------------
    task automatic send_element(input t_data value, input logic is_final);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_element_value <= value;
        i_final_element <= is_final;
        do @(posedge i_clk); while (!o_in_ready);
        predict_sorted_list(value, is_final);
    endtask

    task automatic send_list(input t_data values[$]);
        foreach (values[k]) begin
            send_element(values[k], k == values.size() - 1);
        end
    endtask

    // pick an element: full range, a narrow band that forces ties, or an extreme
    function automatic t_data random_element();
        t_data value;
        case ($urandom_range(5))
            0, 1, 2: value = t_data'($urandom);
            3, 4:    value = t_data'(int'($urandom_range(8)) - 4);
            default: begin
                case ($urandom_range(3))
                    0:       value = MOST_NEGATIVE;
                    1:       value = MOST_POSITIVE;
                    2:       value = '0;
                    default: value = -1;
                endcase
            end
        endcase
        return value;
    endfunction

    // ------------------------------------------------------------------------
    // Checker: compare every output transaction with the oldest expectation,
    // then draw the ready for the next cycle from the current stall rate.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_sorted_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: value %0d last %b overflow %b",
                         $time, o_sorted_value, o_last_of_list, o_overflow);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_sorted_value !== exp_r.sorted_value) begin
                    error_count++;
                    $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                             $time, exp_r.sorted_value, o_sorted_value);
                end
                if (o_last_of_list !== exp_r.last_of_list) begin
                    error_count++;
                    $display("%0t: last_of_list mismatch: expected %b, actual %b",
                             $time, exp_r.last_of_list, o_last_of_list);
                end
                if (o_overflow !== exp_r.overflow) begin
                    error_count++;
                    $display("%0t: overflow mismatch: expected %b, actual %b",
                             $time, exp_r.overflow, o_overflow);
                end
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // single-element lists at both extremes, mixed extremes, ties, sorted and
    // reverse-sorted input
    task automatic test_directed_lists();
        send_list('{MOST_POSITIVE});
        send_list('{MOST_NEGATIVE});
        send_list('{t_data'(0), t_data'(-1), t_data'(1), MOST_POSITIVE, MOST_NEGATIVE});
        send_list('{t_data'(7), t_data'(-7), t_data'(7), t_data'(7)});
        send_list('{t_data'(1), t_data'(2), t_data'(3), t_data'(4), t_data'(5)});
        send_list('{t_data'(5), t_data'(4), t_data'(3), t_data'(2), t_data'(1)});
    endtask

    // fill the chain exactly and push one more as the final element, which is
    // dropped; the list after the overflow must come out clean
    task automatic test_capacity_overflow();
        t_data values[$];
        for (int i = 0; i < MAX_ELEMENTS + 1; i++) begin
            values.push_back(random_element());
        end
        send_list(values);
        send_list('{MOST_NEGATIVE, MOST_POSITIVE});
    endtask

    // random lists, mostly short, until the element budget is spent
    task automatic test_random_lists(input int element_budget);
        t_data values[$];
        int    sent_here;
        int    list_len;
        sent_here = 0;
        while (sent_here < element_budget) begin
            list_len = ($urandom_range(4) == 0) ? $urandom_range(24, 9)
                                                : $urandom_range(8, 1);
            values.delete();
            for (int i = 0; i < list_len; i++) begin
                values.push_back(random_element());
            end
            send_list(values);
            sent_here += list_len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender mostly busy, receiver stalling often
        send_idle_pct = 7;
        recv_idle_pct = 57;
        test_directed_lists();
        test_random_lists(8);

        // sender gapping often, receiver mostly ready
        send_idle_pct = 57;
        recv_idle_pct = 7;
        test_capacity_overflow();
        test_random_lists(8);

        // full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_lists(8);

        i_in_valid <= 1'b0;

        // drain, then hold long enough for a full settle and emit
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (3 * MAX_ELEMENTS + 16) @(posedge i_clk);

        $display("Covered %0d lists (%0d over capacity), %0d elements sent,",
                 lists_sent, overflow_lists, elements_sent);
        $display("%0d sorted results received, %0d errors", results_seen, error_count);
        if (error_count == 0) begin
            $display("tb_descending_sort_engine_unit OK");
        end else begin
            $display("tb_descending_sort_engine_unit NOT OK");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timeout with %0d results still expected", expected_results.size());
        $display("tb_descending_sort_engine_unit NOT OK");
        $finish;
    end

endmodule

// File: files.f
rtl/dse_pkg.sv
rtl/dse_cell.sv
rtl/descending_sort_engine_unit.sv
rtl/dse_checker.sv
sim/tb_descending_sort_engine_unit.sv
